>>> rtl/core/eqc_pkg.sv
// Shared types and constants for the multichannel biquad equalizer cascade.
// Used by every module of the block but eqc_ram; depends on nothing.
package eqc_pkg;

    localparam int SAMPLE_W  = 24;
    localparam int COEF_W    = 32;
    localparam int COEF_FRAC = COEF_W - 4;
    localparam int NUM_TERMS = 5;
    localparam int ACC_W     = SAMPLE_W + COEF_W + 3;

    localparam logic [1:0] CMD_FILTER = 2'd0;
    localparam logic [1:0] CMD_COEF   = 2'd1;
    localparam logic [1:0] CMD_ENABLE = 2'd2;

    localparam logic [2:0] TERM_B0 = 3'd0;
    localparam logic [2:0] TERM_B1 = 3'd1;
    localparam logic [2:0] TERM_B2 = 3'd2;
    localparam logic [2:0] TERM_A1 = 3'd3;
    localparam logic [2:0] TERM_A2 = 3'd4;

    typedef struct packed {
        logic [1:0]                 cmd;
        logic [2:0]                 channel;
        logic [1:0]                 band;
        logic [2:0]                 term_index;
        logic signed [COEF_W-1:0]   coef_value;
        logic                       band_on;
        logic signed [SAMPLE_W-1:0] sample_in;
    } req_t;

    typedef struct packed {
        logic [2:0]                 out_channel;
        logic signed [SAMPLE_W-1:0] sample_out;
        logic                       clipped;
    } rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BAND,
        ST_MAC,
        ST_ACC,
        ST_WB,
        ST_DONE
    } state_t;

    // Controls from the sequencer to the multiply-accumulate unit.
    typedef struct packed {
        logic mul_en;
        logic mul_neg;
        logic acc_load;
        logic acc_en;
    } mac_ctrl_t;

    // Coefficients that a stage holds until it is first written (Q3.28 peak filter).
    function automatic logic signed [COEF_W-1:0] coef_reset(input logic [2:0] term);
        logic signed [COEF_W-1:0] c;
        case (term)
            TERM_B0: c = 32'sd279631899;
            TERM_B1: c = -32'sd363715816;
            TERM_B2: c = 32'sd234739827;
            TERM_A1: c = -32'sd363715816;
            TERM_A2: c = 32'sd245936270;
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage

>>> rtl/core/eqc_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read.
// Depends on nothing.
module eqc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/core/eqc_mac.sv
// Shared multiply-accumulate unit with rounding and saturation of the result.
// Depends on eqc_pkg.
module eqc_mac (
    input  logic                                 clk,
    input  eqc_pkg::mac_ctrl_t                   ctrl,
    input  logic signed [eqc_pkg::COEF_W-1:0]    coef,
    input  logic signed [eqc_pkg::SAMPLE_W-1:0]  opnd,
    output logic signed [eqc_pkg::SAMPLE_W-1:0]  y,
    output logic                                 sat
);

    localparam int SW = eqc_pkg::SAMPLE_W;
    localparam int PW = eqc_pkg::SAMPLE_W + eqc_pkg::COEF_W;
    localparam int AW = eqc_pkg::ACC_W;
    localparam logic signed [AW-1:0] ROUND = AW'(1) << (eqc_pkg::COEF_FRAC - 1);
    localparam logic signed [AW-1:0] SMAX = {{(AW-SW+1){1'b0}}, {(SW-1){1'b1}}};
    localparam logic signed [AW-1:0] SMIN = {{(AW-SW+1){1'b1}}, {(SW-1){1'b0}}};

    logic signed [PW-1:0] prod_reg;
    logic                 neg_reg;
    logic signed [AW-1:0] acc_reg;
    logic signed [AW-1:0] term_ext;
    logic signed [AW-1:0] rnd;
    logic signed [AW-1:0] shifted;

    always_ff @(posedge clk)
    begin
        if (ctrl.mul_en)
        begin
            prod_reg <= coef * opnd;
            neg_reg  <= ctrl.mul_neg;
        end
        if (ctrl.acc_load)
        begin
            acc_reg <= term_ext;
        end
        else if (ctrl.acc_en)
        begin
            acc_reg <= acc_reg + term_ext;
        end
    end

    always_comb
    begin
        term_ext = $signed({{(AW-PW){prod_reg[PW-1]}}, prod_reg});
        if (neg_reg)
        begin
            term_ext = -term_ext;
        end
        rnd     = acc_reg + ROUND;
        shifted = rnd >>> eqc_pkg::COEF_FRAC;
        sat     = 1'b0;
        y       = shifted[SW-1:0];
        if (shifted > SMAX)
        begin
            y   = SMAX[SW-1:0];
            sat = 1'b1;
        end
        else if (shifted < SMIN)
        begin
            y   = SMIN[SW-1:0];
            sat = 1'b1;
        end
    end

endmodule

>>> rtl/core/multichannel_biquad_eq_cascade_top.sv
// Top level of the multichannel four-band biquad equalizer cascade.
// Depends on eqc_pkg, eqc_ram and eqc_mac.
//
//  channel | signals                    | item
//  --------+----------------------------+-------------------------------------
//  request | req_valid, req_stall, req  | filter a sample, or write coef/enable
//  result  | rsp_valid, rsp_stall, rsp  | equalized sample of one filter item
//
// A write item does not raise req_stall. A filter item holds req_stall while
// it looks at each band's enable in turn, runs each enabled band on the single
// shared multiplier (five products, one accumulate, one write-back), and then
// posts the result.
// Reset clears the enables and marks all coefficient and history entries as
// never written; such entries read as the default coefficients and as zero.
// A waiting result does not block the next request; only a finished filter
// item waits when the result register is still full.

module multichannel_biquad_eq_cascade_top #(
    parameter int NUM_CHANNELS = 8,
    parameter int NUM_BANDS    = 4
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  eqc_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output eqc_pkg::rsp_t rsp
);

    localparam int SW         = eqc_pkg::SAMPLE_W;
    localparam int CW         = eqc_pkg::COEF_W;
    localparam int ROWS       = NUM_CHANNELS * NUM_BANDS;
    localparam int ROW_W      = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int BAND_W     = (NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1;
    localparam int COEF_DEPTH = ROWS * eqc_pkg::NUM_TERMS;
    localparam int COEF_AW    = $clog2(COEF_DEPTH);

    eqc_pkg::state_t state_reg, state_next;

    logic [2:0]          ch_reg, ch_next;
    logic [BAND_W-1:0]   b_reg, b_next;
    logic [2:0]          term_reg, term_next;
    logic signed [SW-1:0] x_reg, x_next;
    logic                clip_reg, clip_next;
    logic [ROWS-1:0]     en_reg, en_next;
    logic [ROWS-1:0]     hval_reg, hval_next;
    logic [COEF_DEPTH-1:0] cval_reg, cval_next;
    logic                hval_rd_reg, cval_rd_reg;
    logic                rsp_valid_reg, rsp_valid_next;
    eqc_pkg::rsp_t       rsp_reg, rsp_next;

    logic                accept;
    logic                ch_ok, band_ok, term_ok;
    logic [ROW_W-1:0]    wrow, row_cur;
    logic                last_band;
    logic [2:0]          issue;
    logic                coef_we;
    logic [COEF_AW-1:0]  coef_waddr, coef_raddr;
    logic [CW-1:0]       coef_rdata;
    logic signed [CW-1:0] coef_eff;
    logic                hist_we;
    logic [4*SW-1:0]     hist_wdata, hist_rdata, hist_eff;
    logic signed [SW-1:0] opnd;
    logic signed [SW-1:0] mac_y;
    logic                mac_sat;
    eqc_pkg::mac_ctrl_t  mac_ctrl;

    assign accept    = req_valid && !req_stall;
    assign req_stall = (state_reg != eqc_pkg::ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign ch_ok   = (32'(req.channel) < NUM_CHANNELS);
    assign band_ok = (32'(req.band) < NUM_BANDS);
    assign term_ok = (req.term_index <= eqc_pkg::TERM_A2);

    // Rows are laid out channel-major, band-minor; a row holds five terms.
    assign wrow      = ROW_W'(req.channel) * ROW_W'(NUM_BANDS) + ROW_W'(req.band);
    assign row_cur   = ROW_W'(ch_reg) * ROW_W'(NUM_BANDS) + ROW_W'(b_reg);
    assign last_band = (b_reg == BAND_W'(NUM_BANDS - 1));

    // The coefficient read runs one term ahead of the multiplier.
    assign issue = (state_reg == eqc_pkg::ST_MAC && term_reg != eqc_pkg::TERM_A2)
                   ? term_reg + 3'd1 : eqc_pkg::TERM_B0;
    assign coef_raddr = COEF_AW'(row_cur) * COEF_AW'(eqc_pkg::NUM_TERMS) + COEF_AW'(issue);
    assign coef_waddr = COEF_AW'(wrow) * COEF_AW'(eqc_pkg::NUM_TERMS)
                        + COEF_AW'(req.term_index);
    assign coef_we    = accept && ch_ok && band_ok && term_ok
                        && (req.cmd == eqc_pkg::CMD_COEF);

    assign coef_eff = cval_rd_reg ? $signed(coef_rdata) : eqc_pkg::coef_reset(term_reg);
    assign hist_eff = hval_rd_reg ? hist_rdata : '0;

    // History of a row is {x1, x2, y1, y2}. Each row is read and rewritten
    // within one band pass, and no other pass touches it in between, so the
    // read-modify-write needs no forwarding.
    assign hist_we    = (state_reg == eqc_pkg::ST_WB);
    assign hist_wdata = {x_reg, hist_eff[4*SW-1:3*SW], mac_y, hist_eff[2*SW-1:SW]};

    eqc_ram #(.WIDTH(CW), .DEPTH(COEF_DEPTH)) u_coef_ram (
        .clk   (clk),
        .we    (coef_we),
        .waddr (coef_waddr),
        .wdata (req.coef_value),
        .raddr (coef_raddr),
        .rdata (coef_rdata)
    );

    eqc_ram #(.WIDTH(4 * SW), .DEPTH(ROWS)) u_hist_ram (
        .clk   (clk),
        .we    (hist_we),
        .waddr (row_cur),
        .wdata (hist_wdata),
        .raddr (row_cur),
        .rdata (hist_rdata)
    );

    always_comb
    begin
        case (term_reg)
            eqc_pkg::TERM_B0: opnd = x_reg;
            eqc_pkg::TERM_B1: opnd = hist_eff[4*SW-1:3*SW];
            eqc_pkg::TERM_B2: opnd = hist_eff[3*SW-1:2*SW];
            eqc_pkg::TERM_A1: opnd = hist_eff[2*SW-1:SW];
            eqc_pkg::TERM_A2: opnd = hist_eff[SW-1:0];
            default:          opnd = '0;
        endcase
    end

    always_comb
    begin
        mac_ctrl.mul_en   = (state_reg == eqc_pkg::ST_MAC);
        mac_ctrl.mul_neg  = (term_reg >= eqc_pkg::TERM_A1);
        mac_ctrl.acc_load = (state_reg == eqc_pkg::ST_MAC) && (term_reg == eqc_pkg::TERM_B1);
        mac_ctrl.acc_en   = ((state_reg == eqc_pkg::ST_MAC) && (term_reg >= eqc_pkg::TERM_B2))
                            || (state_reg == eqc_pkg::ST_ACC);
    end

    eqc_mac u_mac (
        .clk  (clk),
        .ctrl (mac_ctrl),
        .coef (coef_eff),
        .opnd (opnd),
        .y    (mac_y),
        .sat  (mac_sat)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= eqc_pkg::ST_IDLE;
            en_reg        <= '0;
            hval_reg      <= '0;
            cval_reg      <= '0;
            rsp_valid_reg <= 1'b0;
            hval_rd_reg   <= 1'b0;
            cval_rd_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            en_reg        <= en_next;
            hval_reg      <= hval_next;
            cval_reg      <= cval_next;
            rsp_valid_reg <= rsp_valid_next;
            hval_rd_reg   <= hval_reg[row_cur];
            cval_rd_reg   <= cval_reg[coef_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        ch_reg   <= ch_next;
        b_reg    <= b_next;
        term_reg <= term_next;
        x_reg    <= x_next;
        clip_reg <= clip_next;
        rsp_reg  <= rsp_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        ch_next        = ch_reg;
        b_next         = b_reg;
        term_next      = term_reg;
        x_next         = x_reg;
        clip_next      = clip_reg;
        en_next        = en_reg;
        hval_next      = hval_reg;
        cval_next      = cval_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;

        if (coef_we)
        begin
            cval_next[coef_waddr] = 1'b1;
        end

        case (state_reg)
            eqc_pkg::ST_IDLE:
            begin
                if (accept && ch_ok)
                begin
                    if (req.cmd == eqc_pkg::CMD_ENABLE && band_ok)
                    begin
                        en_next[wrow] = req.band_on;
                    end
                    if (req.cmd == eqc_pkg::CMD_FILTER)
                    begin
                        ch_next    = req.channel;
                        b_next     = '0;
                        x_next     = req.sample_in;
                        clip_next  = 1'b0;
                        term_next  = eqc_pkg::TERM_B0;
                        state_next = eqc_pkg::ST_BAND;
                    end
                end
            end
            eqc_pkg::ST_BAND:
            begin
                term_next = eqc_pkg::TERM_B0;
                if (en_reg[row_cur])
                begin
                    state_next = eqc_pkg::ST_MAC;
                end
                else if (last_band)
                begin
                    state_next = eqc_pkg::ST_DONE;
                end
                else
                begin
                    b_next = b_reg + BAND_W'(1);
                end
            end
            eqc_pkg::ST_MAC:
            begin
                term_next = term_reg + 3'd1;
                if (term_reg == eqc_pkg::TERM_A2)
                begin
                    state_next = eqc_pkg::ST_ACC;
                end
            end
            eqc_pkg::ST_ACC:
            begin
                state_next = eqc_pkg::ST_WB;
            end
            eqc_pkg::ST_WB:
            begin
                hval_next[row_cur] = 1'b1;
                x_next             = mac_y;
                clip_next          = clip_reg | mac_sat;
                if (last_band)
                begin
                    state_next = eqc_pkg::ST_DONE;
                end
                else
                begin
                    b_next     = b_reg + BAND_W'(1);
                    state_next = eqc_pkg::ST_BAND;
                end
            end
            eqc_pkg::ST_DONE:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_next.out_channel = ch_reg;
                    rsp_next.sample_out  = x_reg;
                    rsp_next.clipped     = clip_reg;
                    rsp_valid_next       = 1'b1;
                    state_next           = eqc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = eqc_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/core/eqc_chk.sv
// Port-level checker for the equalizer cascade, bound to the top level.
// Depends on eqc_pkg and multichannel_biquad_eq_cascade_top.
module eqc_chk #(
    parameter int NUM_CHANNELS = 8
) (
    input logic          clk,
    input logic          rst_n,
    input logic          req_valid,
    input logic          req_stall,
    input eqc_pkg::req_t req,
    input logic          rsp_valid,
    input logic          rsp_stall,
    input eqc_pkg::rsp_t rsp
);

    // A held result keeps its value until it is taken.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("result changed while stalled");

    // A filter item for a real channel keeps the request side busy.
    a_filter_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall && req.cmd == eqc_pkg::CMD_FILTER
        && 32'(req.channel) < NUM_CHANNELS |=> req_stall)
        else $error("filter item did not occupy the block");

    // Any other item is finished in its own cycle.
    a_write_fast: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall && req.cmd != eqc_pkg::CMD_FILTER |=> !req_stall)
        else $error("write item held the request side");

    // Results only name channels that exist.
    a_rsp_channel: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> 32'(rsp.out_channel) < NUM_CHANNELS)
        else $error("result for a channel out of range");

endmodule

bind multichannel_biquad_eq_cascade_top eqc_chk #(.NUM_CHANNELS(NUM_CHANNELS)) u_eqc_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);

>>> tb/tb.sv
// Self-checking testbench for the multichannel biquad equalizer cascade.
// Drives request items through a valid/stall handshake and checks each result.
// Depends on eqc_pkg and multichannel_biquad_eq_cascade_top.
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NCH        = 8;
    localparam int NBANDS     = 4;
    localparam int WATCHDOG   = 20000;
    localparam int RAND_ITEMS = 1000;

    logic           clk = 1'b0;
    logic           rst_n = 1'b0;
    logic           req_valid = 1'b0;
    logic           req_stall;
    eqc_pkg::req_t  req = '0;
    logic           rsp_valid;
    logic           rsp_stall = 1'b1;
    eqc_pkg::rsp_t  rsp;

    // Model of the equalizer state: coefficients, enables and per-stage history.
    logic signed [eqc_pkg::COEF_W-1:0] eq_coef [NCH][NBANDS][eqc_pkg::NUM_TERMS];
    logic                              eq_on   [NCH][NBANDS];
    longint                            hx1 [NCH][NBANDS];
    longint                            hx2 [NCH][NBANDS];
    longint                            hy1 [NCH][NBANDS];
    longint                            hy2 [NCH][NBANDS];

    eqc_pkg::rsp_t pending_eq [$];
    int     error_count = 0;
    int     idle_cycles = 0;
    bit     long_hold = 1'b0;

    multichannel_biquad_eq_cascade_top #(
        .NUM_CHANNELS(NCH),
        .NUM_BANDS   (NBANDS)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req      (req),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp      (rsp)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        error_count++;
        $display("ERROR %0t: %s got %0d expected %0d", $realtime, what, got, want);
    endtask

    task automatic reset_eq_model();
        for (int c = 0; c < NCH; c++)
            for (int b = 0; b < NBANDS; b++)
            begin
                for (int t = 0; t < eqc_pkg::NUM_TERMS; t++)
                    eq_coef[c][b][t] = (t == 0) ? 32'sd279631899 :
                                       (t == 1) ? -32'sd363715816 :
                                       (t == 2) ? 32'sd234739827 :
                                       (t == 3) ? -32'sd363715816 : 32'sd245936270;
                eq_on[c][b] = 1'b0;
                hx1[c][b] = 0; hx2[c][b] = 0; hy1[c][b] = 0; hy2[c][b] = 0;
            end
    endtask

    // Applies one accepted item to the model and queues the equalized sample it causes.
    task automatic equalize_item(input eqc_pkg::req_t r);
        longint x, acc, y, smax, smin;
        bit     clip;
        eqc_pkg::rsp_t e;
        smax = (64'sd1 <<< (eqc_pkg::SAMPLE_W - 1)) - 1;
        smin = -smax - 1;
        if (r.channel >= NCH)
            return;
        if (r.cmd == eqc_pkg::CMD_COEF)
        begin
            if (r.band < NBANDS && r.term_index < eqc_pkg::NUM_TERMS)
                eq_coef[r.channel][r.band][r.term_index] = r.coef_value;
            return;
        end
        if (r.cmd == eqc_pkg::CMD_ENABLE)
        begin
            if (r.band < NBANDS)
                eq_on[r.channel][r.band] = r.band_on;
            return;
        end
        if (r.cmd != eqc_pkg::CMD_FILTER)
            return;
        x = longint'(r.sample_in);
        clip = 1'b0;
        for (int b = 0; b < NBANDS; b++)
        begin
            if (!eq_on[r.channel][b])
                continue;
            acc = longint'(eq_coef[r.channel][b][0]) * x
                + longint'(eq_coef[r.channel][b][1]) * hx1[r.channel][b]
                + longint'(eq_coef[r.channel][b][2]) * hx2[r.channel][b]
                - longint'(eq_coef[r.channel][b][3]) * hy1[r.channel][b]
                - longint'(eq_coef[r.channel][b][4]) * hy2[r.channel][b];
            // Round half up, then floor back to sample precision.
            y = (acc + (64'sd1 <<< (eqc_pkg::COEF_FRAC - 1))) >>> eqc_pkg::COEF_FRAC;
            if (y > smax) begin y = smax; clip = 1'b1; end
            if (y < smin) begin y = smin; clip = 1'b1; end
            hx2[r.channel][b] = hx1[r.channel][b];
            hx1[r.channel][b] = x;
            hy2[r.channel][b] = hy1[r.channel][b];
            hy1[r.channel][b] = y;
            x = y;
        end
        e.out_channel = r.channel;
        e.sample_out  = x[eqc_pkg::SAMPLE_W-1:0];
        e.clipped     = clip;
        pending_eq.push_back(e);
    endtask

    function automatic eqc_pkg::req_t make_req(input logic [1:0] cmd, input int ch,
                                               input int band, input int term,
                                               input logic [31:0] coef,
                                               input int on, input int smp);
        eqc_pkg::req_t r;
        r.cmd = cmd; r.channel = 3'(ch); r.band = 2'(band); r.term_index = 3'(term);
        r.coef_value = coef; r.band_on = 1'(on); r.sample_in = 24'(smp);
        return r;
    endfunction

    // Directed rows; a row with a typed-in expectation is checked against it as well.
    typedef struct {
        eqc_pkg::req_t item;
        bit            has_want;
        eqc_pkg::rsp_t want;
    } dir_row_t;

    dir_row_t      dir_rows [$];
    eqc_pkg::rsp_t typed_wants [$];

    task automatic add_row(input eqc_pkg::req_t r, input bit hw, input eqc_pkg::rsp_t w);
        dir_row_t d;
        d.item = r; d.has_want = hw; d.want = w;
        dir_rows.push_back(d);
    endtask

    // Offers one item after a random gap and waits for it to be accepted.
    task automatic send_item(input eqc_pkg::req_t r);
        int gap;
        gap = $urandom_range(0, 5);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap != 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req <= r;
        do
            @(posedge clk);
        while (req_stall);
        equalize_item(r);
    endtask

    function automatic eqc_pkg::req_t random_item();
        eqc_pkg::req_t r;
        int   k;
        r = make_req(eqc_pkg::CMD_FILTER, $urandom_range(0, 7), $urandom_range(0, 3),
                     $urandom_range(0, 4), $urandom, $urandom_range(0, 1), $urandom);
        k = $urandom_range(0, 99);
        if (k < 65)
        begin
            r.cmd = eqc_pkg::CMD_FILTER;
            // Mostly modest samples keep the cascade out of permanent saturation.
            if ($urandom_range(0, 3) != 0)
                r.sample_in = $signed(24'($urandom_range(0, 65535))) - 24'sd32768;
        end
        else if (k < 80)
        begin
            r.cmd = eqc_pkg::CMD_COEF;
            // Mostly gentle coefficients in Q3.28, sometimes anything at all.
            if ($urandom_range(0, 3) != 0)
                r.coef_value = $signed(32'($urandom_range(0, 32'h1FFF_FFFF))) - 32'sh1000_0000;
        end
        else if (k < 95)
            r.cmd = eqc_pkg::CMD_ENABLE;
        else
        begin
            r.cmd = 2'd3;
            r.term_index = 3'($urandom_range(0, 7));
        end
        if ($urandom_range(0, 19) == 0)
            r.term_index = 3'($urandom_range(5, 7));
        return r;
    endfunction

    // Result side: random stalls, one long hold-off, and the field-by-field check.
    initial
    begin
        int   wait_n;
        eqc_pkg::rsp_t e;
        @(posedge rst_n);
        forever
        begin
            if (long_hold)
            begin
                rsp_stall <= 1'b1;
                repeat (400) @(posedge clk);
                long_hold = 1'b0;
            end
            wait_n = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 5);
            if (wait_n != 0)
            begin
                rsp_stall <= 1'b1;
                repeat (wait_n) @(posedge clk);
            end
            rsp_stall <= 1'b0;
            do
                @(posedge clk);
            while (!rsp_valid);
            if (pending_eq.size() == 0)
                report_mismatch("unexpected result, channel", rsp.out_channel, -1);
            else
            begin
                e = pending_eq.pop_front();
                if (rsp.out_channel !== e.out_channel)
                    report_mismatch("out_channel", rsp.out_channel, e.out_channel);
                if (rsp.sample_out !== e.sample_out)
                    report_mismatch("sample_out", rsp.sample_out, e.sample_out);
                if (rsp.clipped !== e.clipped)
                    report_mismatch("clipped", rsp.clipped, e.clipped);
                if (typed_wants.size() != 0 && rsp.out_channel == typed_wants[0].out_channel)
                begin
                    if (rsp !== typed_wants[0])
                        report_mismatch("directed sample_out", rsp.sample_out,
                                        typed_wants[0].sample_out);
                    void'(typed_wants.pop_front());
                end
            end
        end
    end

    // Watchdog: counts cycles with no accepted item on either side.
    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // Stimulus: reset, the directed table, then random items with a long hold-off.
    initial
    begin
        eqc_pkg::rsp_t nw;
        reset_eq_model();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        nw = '0;
        // After reset every band is off, so samples come back unchanged and unclipped.
        nw.out_channel = 3'd0; nw.sample_out = 24'sh7FFFFF;
        add_row(make_req(eqc_pkg::CMD_FILTER, 0, 0, 0, 0, 0, 'h7FFFFF), 1, nw);
        nw.out_channel = 3'd7; nw.sample_out = 24'sh800000;
        add_row(make_req(eqc_pkg::CMD_FILTER, 7, 0, 0, 0, 0, 'h800000), 1, nw);
        nw.out_channel = 3'd3; nw.sample_out = 24'sh000000;
        add_row(make_req(eqc_pkg::CMD_FILTER, 3, 0, 0, 0, 0, 0), 1, nw);
        // Enable band 0 of channel 1 with its default peak coefficients.
        add_row(make_req(eqc_pkg::CMD_ENABLE, 1, 0, 0, 0, 1, 0), 0, nw);
        add_row(make_req(eqc_pkg::CMD_FILTER, 1, 0, 0, 0, 0, 'h400000), 0, nw);
        add_row(make_req(eqc_pkg::CMD_FILTER, 1, 0, 0, 0, 0, 'h800000), 0, nw);
        // Extreme coefficients on b0, b1, b2 and a1 of band 3, zero on a2, then enable all bands.
        add_row(make_req(eqc_pkg::CMD_COEF, 1, 3, eqc_pkg::TERM_B0, 32'h7FFFFFFF, 0, 0), 0, nw);
        add_row(make_req(eqc_pkg::CMD_COEF, 1, 3, eqc_pkg::TERM_B1, 32'h80000000, 0, 0), 0, nw);
        add_row(make_req(eqc_pkg::CMD_COEF, 1, 3, eqc_pkg::TERM_B2, 32'h7FFFFFFF, 0, 0), 0, nw);
        add_row(make_req(eqc_pkg::CMD_COEF, 1, 3, eqc_pkg::TERM_A1, 32'h80000000, 0, 0), 0, nw);
        add_row(make_req(eqc_pkg::CMD_COEF, 1, 3, eqc_pkg::TERM_A2, 32'h00000000, 0, 0), 0, nw);
        add_row(make_req(eqc_pkg::CMD_ENABLE, 1, 1, 0, 0, 1, 0), 0, nw);
        add_row(make_req(eqc_pkg::CMD_ENABLE, 1, 2, 0, 0, 1, 0), 0, nw);
        add_row(make_req(eqc_pkg::CMD_ENABLE, 1, 3, 0, 0, 1, 0), 0, nw);
        add_row(make_req(eqc_pkg::CMD_FILTER, 1, 0, 0, 0, 0, 'h7FFFFF), 0, nw);
        add_row(make_req(eqc_pkg::CMD_FILTER, 1, 0, 0, 0, 0, 'h800000), 0, nw);
        // Unused command and out-of-range term are ignored.
        add_row(make_req(2'd3, 1, 0, 0, 0, 1, 'h123456), 0, nw);
        add_row(make_req(eqc_pkg::CMD_COEF, 1, 0, 7, 32'h12345678, 0, 0), 0, nw);
        // Disabling a band keeps its history for when it comes back.
        add_row(make_req(eqc_pkg::CMD_ENABLE, 1, 0, 0, 0, 0, 0), 0, nw);
        add_row(make_req(eqc_pkg::CMD_FILTER, 1, 0, 0, 0, 0, 'h001000), 0, nw);
        add_row(make_req(eqc_pkg::CMD_ENABLE, 1, 0, 0, 0, 1, 0), 0, nw);
        add_row(make_req(eqc_pkg::CMD_FILTER, 1, 0, 0, 0, 0, 'hFFF000), 0, nw);
        add_row(make_req(eqc_pkg::CMD_ENABLE, 1, 3, 0, 0, 0, 0), 0, nw);

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].has_want)
                typed_wants.push_back(dir_rows[i].want);
            send_item(dir_rows[i].item);
        end

        for (int n = 0; n < RAND_ITEMS; n++)
        begin
            // Midway the receiver holds off while filter items keep coming.
            if (n == RAND_ITEMS / 2)
                long_hold = 1'b1;
            send_item(random_item());
        end
        req_valid <= 1'b0;

        while (pending_eq.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

>>> sim.f
rtl/core/eqc_pkg.sv
rtl/core/eqc_ram.sv
rtl/core/eqc_mac.sv
rtl/core/multichannel_biquad_eq_cascade_top.sv
rtl/core/eqc_chk.sv
tb/tb.sv
